@@ design/chr_bank_switch_mapper_unit_defines.svh @@
// Assertion macros for the CHR bank switch mapper.
// Used by the top level only; depends on nothing else.
`ifndef CHR_BANK_SWITCH_MAPPER_UNIT_DEFINES_SVH
`define CHR_BANK_SWITCH_MAPPER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBSM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chr_bank_switch_mapper assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CBSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chr_bank_switch_mapper assertion failed");

`endif

@@ design/chr_bsm_pkg.sv @@
// Shared types and constants for the CHR bank switch mapper.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package chr_bsm_pkg;

  localparam int FUNC_W       = 3;
  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 3;

  localparam int PRG_AW       = 15;
  localparam int PRG_DEPTH    = 32768;
  localparam int NT_AW        = 11;
  localparam int NT_DEPTH     = 2048;
  localparam int CHR_BANK_AW  = 13;
  localparam int CHR_BANK_BYTES = 8192;

  localparam logic [FUNC_W-1:0] FUNC_CPU_READ  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CPU_WRITE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PPU_READ  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PPU_WRITE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_PRG  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CPU_LOW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CHR_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_LOAD_RANGE = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANKS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANKS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_MODE = 2'd2;

  // Which store feeds the result of the access in flight.
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_PRG,
    SEL_CHR,
    SEL_NT
  } read_sel_t;

  typedef struct packed {
    logic start;
    logic capture;
  } ctrl_cmd_t;

endpackage

@@ design/chr_bsm_ram.sv @@
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module chr_bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ design/chr_bsm_ctrl.sv @@
// Controller for the CHR bank switch mapper: handshakes and sequencing.
// Depends on chr_bsm_pkg.
`timescale 1ns / 1ps

module chr_bsm_ctrl
  import chr_bsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_ACCESS = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready    = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.start   = in_valid && in_ready;
  assign cmd.capture = (state == S_ACCESS);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (cmd.start) begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/chr_bsm_datapath.sv @@
// Datapath for the CHR bank switch mapper: address decode, bank and
// configuration registers, the three stores and the result register.
// Depends on chr_bsm_pkg and chr_bsm_ram.
`timescale 1ns / 1ps

module chr_bsm_datapath
  import chr_bsm_pkg::*;
#(
  parameter int CHR_BANK_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  ctrl_cmd_t              cmd,
  input  logic [IN_TDATA_W-1:0]  in_data,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int CHR_DEPTH = CHR_BANK_COUNT * CHR_BANK_BYTES;
  localparam int CHR_AW    = $clog2(CHR_DEPTH);
  localparam logic [2:0] CHR_COUNT_V = 3'(CHR_BANK_COUNT);

  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  logic [1:0] prg_banks;
  logic [2:0] chr_banks;
  logic       mirror_mode;
  logic [1:0] chr_bank;

  logic              prg_en, prg_we, chr_en, chr_we, nt_en, nt_we, bank_we;
  logic [PRG_AW-1:0] prg_addr;
  logic [CHR_AW-1:0] chr_addr;
  logic [NT_AW-1:0]  nt_addr;
  logic [DATA_W-1:0] prg_rdata, chr_rdata, nt_rdata;
  logic [2:0]        chr_present;
  logic [14:0]       chr_full;
  read_sel_t         acc_sel;
  logic [STATUS_W-1:0] acc_status;

  read_sel_t           sel;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_data;
  logic [STATUS_W-1:0] out_status;

  assign func       = in_data[2:0];
  assign address    = in_data[18:3];
  assign write_data = in_data[26:19];

  assign chr_present = (chr_banks < CHR_COUNT_V) ? chr_banks : CHR_COUNT_V;
  assign chr_full    = {chr_bank, address[12:0]};
  assign chr_addr    = chr_full[CHR_AW-1:0];
  assign nt_addr     = {(mirror_mode ? address[10] : address[11]), address[9:0]};

  always_comb begin
    prg_en     = 1'b0;
    prg_we     = 1'b0;
    prg_addr   = address[14:0];
    chr_en     = 1'b0;
    chr_we     = 1'b0;
    nt_en      = 1'b0;
    nt_we      = 1'b0;
    bank_we    = 1'b0;
    acc_sel    = SEL_NONE;
    acc_status = STATUS_OK;
    case (func)
      FUNC_CPU_READ: begin
        if (address[15]) begin
          prg_en  = 1'b1;
          acc_sel = SEL_PRG;
          if (!prg_banks[1]) begin
            prg_addr[14] = 1'b0;
          end
        end else begin
          acc_status = STATUS_CPU_LOW;
        end
      end
      FUNC_CPU_WRITE: begin
        bank_we = 1'b1;
      end
      FUNC_PPU_READ, FUNC_PPU_WRITE: begin
        if (address[15:13] == 3'd0) begin
          if ({1'b0, chr_bank} < chr_present) begin
            chr_en = 1'b1;
            if (func == FUNC_PPU_WRITE) begin
              chr_we = 1'b1;
            end else begin
              acc_sel = SEL_CHR;
            end
          end else begin
            acc_status = STATUS_CHR_RANGE;
          end
        end else begin
          nt_en = 1'b1;
          if (func == FUNC_PPU_WRITE) begin
            nt_we = 1'b1;
          end else begin
            acc_sel = SEL_NT;
          end
        end
      end
      FUNC_LOAD_PRG: begin
        if (!address[15]) begin
          prg_en = 1'b1;
          prg_we = 1'b1;
        end else begin
          acc_status = STATUS_LOAD_RANGE;
        end
      end
      default: begin
        acc_sel = SEL_NONE;
      end
    endcase
  end

  chr_bsm_ram #(.WIDTH(DATA_W), .DEPTH(PRG_DEPTH)) u_prg_ram (
    .clk   (clk),
    .en    (cmd.start && prg_en),
    .we    (prg_we),
    .addr  (prg_addr),
    .wdata (write_data),
    .rdata (prg_rdata)
  );

  chr_bsm_ram #(.WIDTH(DATA_W), .DEPTH(CHR_DEPTH)) u_chr_ram (
    .clk   (clk),
    .en    (cmd.start && chr_en),
    .we    (chr_we),
    .addr  (chr_addr),
    .wdata (write_data),
    .rdata (chr_rdata)
  );

  chr_bsm_ram #(.WIDTH(DATA_W), .DEPTH(NT_DEPTH)) u_nt_ram (
    .clk   (clk),
    .en    (cmd.start && nt_en),
    .we    (nt_we),
    .addr  (nt_addr),
    .wdata (write_data),
    .rdata (nt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks   <= 2'd2;
      chr_banks   <= 3'd4;
      mirror_mode <= 1'b0;
      chr_bank    <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRG_BANKS:   prg_banks   <= cfg_data[1:0];
          CFG_CHR_BANKS:   chr_banks   <= cfg_data;
          CFG_MIRROR_MODE: mirror_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.start && bank_we) begin
        chr_bank <= write_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sel    <= acc_sel;
      status <= acc_status;
    end
    if (cmd.capture) begin
      out_status <= status;
      case (sel)
        SEL_PRG: read_data <= prg_rdata;
        SEL_CHR: read_data <= chr_rdata;
        SEL_NT:  read_data <= nt_rdata;
        default: read_data <= '0;
      endcase
    end
  end

  assign out_data = {6'd0, out_status, read_data};

endmodule

@@ design/chr_bank_switch_mapper_unit.sv @@
// CHR bank switch mapper: one bus access in, one result out per transfer.
// The stores are read at the transfer edge, and the result register and result valid
// load at the next edge. The input is not ready again while the access is in flight,
// and a result held back by the receiver stalls the input. Reset (synchronous)
// clears the controller, the bank number and the configuration; stores are not
// cleared.
`timescale 1ns / 1ps
`include "chr_bank_switch_mapper_unit_defines.svh"

module chr_bank_switch_mapper_unit
  import chr_bsm_pkg::*;
#(
  parameter int CHR_BANK_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // From bit 0: func[2:0], address[15:0], write_data[7:0], zero fill.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // From bit 0: read_data[7:0], status[1:0], zero fill.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t cmd;

  chr_bsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  chr_bsm_datapath #(.CHR_BANK_COUNT(CHR_BANK_COUNT)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_data   (s_tdata),
    .out_data  (m_tdata)
  );

  `CBSM_ASSERT_NEXT(a_no_accept_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `CBSM_ASSERT_NEXT(a_start_then_capture, clk, rst, cmd.start, cmd.capture)
  `CBSM_ASSERT_NEXT(a_capture_then_valid, clk, rst, cmd.capture, m_tvalid)
  `CBSM_ASSERT_NOW(a_start_needs_room, clk, rst, cmd.start, !m_tvalid || m_tready)

endmodule

@@ bench/chr_bank_switch_mapper_unit_tb.sv @@
// Self-checking testbench for the CHR bank switch mapper unit.
// Drives bus accesses, predicts each result and compares it with the output stream;
// depends on chr_bsm_pkg and chr_bank_switch_mapper_unit.
`timescale 1ns / 1ps

module chr_bank_switch_mapper_unit_tb;
  import chr_bsm_pkg::*;

  localparam int CHR_BANK_COUNT = 4;
  localparam int CHR_DEPTH = CHR_BANK_COUNT * CHR_BANK_BYTES;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam logic [FUNC_W-1:0] FUNC_FIRST_UNUSED = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_LAST_UNUSED = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REGISTER = 2'd3;
  localparam logic MIRROR_HORIZONTAL = 1'b0;
  localparam logic MIRROR_VERTICAL = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [STATUS_W-1:0] status;
  } mapper_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [DATA_W-1:0] prg_mem [PRG_DEPTH];
  logic [DATA_W-1:0] chr_mem [CHR_DEPTH];
  logic [DATA_W-1:0] nt_mem [NT_DEPTH];
  bit prg_written [PRG_DEPTH];
  bit chr_written [CHR_DEPTH];
  bit nt_written [NT_DEPTH];
  logic [PRG_AW-1:0] prg_list [$];
  logic [PRG_AW-1:0] chr_list [$];
  logic [NT_AW-1:0] nt_list [$];
  logic [1:0] chr_bank_sel = 2'd0;
  logic [1:0] cfg_prg_banks = 2'd2;
  logic [2:0] cfg_chr_banks = 3'd4;
  logic cfg_mirror = MIRROR_HORIZONTAL;

  mapper_result_t expected_results [$];
  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_count = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [7:0] pattern_cycle = '0;

  chr_bank_switch_mapper_unit #(.CHR_BANK_COUNT(CHR_BANK_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_count) begin
      hold_seen <= hold_count;
      hold_left <= HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      pattern_cycle <= pattern_cycle + 8'd1;
      case (pattern_cycle[7:6])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= ($urandom_range(0, 1) == 1);
        2'd2: m_tready <= (pattern_cycle[1:0] != 2'd0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    mapper_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no access outstanding: read_data %0h status %0d",
               m_tdata[DATA_W-1:0], m_tdata[DATA_W+STATUS_W-1:DATA_W]);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[DATA_W-1:0] !== want.read_data) begin
          $error("read_data: expected %0h, actual %0h", want.read_data, m_tdata[DATA_W-1:0]);
          fail_count++;
        end
        if (m_tdata[DATA_W+STATUS_W-1:DATA_W] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status,
                 m_tdata[DATA_W+STATUS_W-1:DATA_W]);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [PRG_AW-1:0] prg_slot(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] m;
    m = a - 16'h8000;
    if (cfg_prg_banks < 2) m = m & 16'h3FFF;
    return m[PRG_AW-1:0];
  endfunction

  function automatic bit chr_slot(logic [ADDR_W-1:0] a, output logic [PRG_AW-1:0] idx);
    int unsigned present;
    int unsigned full;
    present = (cfg_chr_banks < CHR_BANK_COUNT) ? cfg_chr_banks : CHR_BANK_COUNT;
    full = chr_bank_sel * CHR_BANK_BYTES + a;
    idx = full[PRG_AW-1:0];
    return full < present * CHR_BANK_BYTES;
  endfunction

  function automatic logic [NT_AW-1:0] nt_slot(logic [ADDR_W-1:0] a);
    logic nt_half;
    nt_half = (cfg_mirror == MIRROR_VERTICAL) ? a[10] : a[11];
    return {nt_half, a[9:0]};
  endfunction

  function automatic bit reads_unwritten(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a);
    logic [PRG_AW-1:0] ci;
    if (f == FUNC_CPU_READ) return a[15] && !prg_written[prg_slot(a)];
    if (f == FUNC_PPU_READ) begin
      if (a >= 16'h2000) return !nt_written[nt_slot(a)];
      return chr_slot(a, ci) && !chr_written[ci];
    end
    return 1'b0;
  endfunction

  task automatic predict_access(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                logic [DATA_W-1:0] d);
    mapper_result_t r;
    logic [PRG_AW-1:0] ci;
    logic [NT_AW-1:0] ni;
    r.read_data = '0;
    r.status = STATUS_OK;
    case (f)
      FUNC_CPU_READ: begin
        if (a[15]) r.read_data = prg_mem[prg_slot(a)];
        else r.status = STATUS_CPU_LOW;
      end
      FUNC_CPU_WRITE: chr_bank_sel = d[1:0];
      FUNC_PPU_READ, FUNC_PPU_WRITE: begin
        if (a < 16'h2000) begin
          if (!chr_slot(a, ci)) begin
            r.status = STATUS_CHR_RANGE;
          end else if (f == FUNC_PPU_READ) begin
            r.read_data = chr_mem[ci];
          end else begin
            chr_mem[ci] = d;
            if (!chr_written[ci]) chr_list.push_back(ci);
            chr_written[ci] = 1'b1;
          end
        end else begin
          ni = nt_slot(a);
          if (f == FUNC_PPU_READ) begin
            r.read_data = nt_mem[ni];
          end else begin
            nt_mem[ni] = d;
            if (!nt_written[ni]) nt_list.push_back(ni);
            nt_written[ni] = 1'b1;
          end
        end
      end
      FUNC_LOAD_PRG: begin
        if (!a[15]) begin
          prg_mem[a[PRG_AW-1:0]] = d;
          if (!prg_written[a[PRG_AW-1:0]]) prg_list.push_back(a[PRG_AW-1:0]);
          prg_written[a[PRG_AW-1:0]] = 1'b1;
        end else begin
          r.status = STATUS_LOAD_RANGE;
        end
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  // A read that would touch a never-written byte is turned into a write of that byte.
  task automatic send_access(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                             logic [DATA_W-1:0] d);
    int gap;
    if (reads_unwritten(f, a)) begin
      if (f == FUNC_CPU_READ) begin
        a = {1'b0, prg_slot(a)};
        f = FUNC_LOAD_PRG;
      end else begin
        f = FUNC_PPU_WRITE;
      end
    end
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= {5'b00000, d, a, f};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    predict_access(f, a, d);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PRG_BANKS: cfg_prg_banks = value[1:0];
      CFG_CHR_BANKS: cfg_chr_banks = value;
      CFG_MIRROR_MODE: cfg_mirror = value[0];
      default: ;
    endcase
  endtask

  task automatic random_access();
    int unsigned pick;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic [PRG_AW-1:0] w;
    logic [NT_AW-1:0] n;
    logic [5:0] bank_hi;
    logic [FUNC_W-1:0] f;
    pick = $urandom_range(0, 99);
    a = 16'($urandom_range(0, 16'hFFFF));
    d = 8'($urandom_range(0, 255));
    if (pick < 14) begin
      a[15] = ($urandom_range(0, 15) == 0);
      send_access(FUNC_LOAD_PRG, a, d);
    end else if (pick < 30) begin
      if (prg_list.size() != 0 && $urandom_range(0, 4) != 0) begin
        w = prg_list[$urandom_range(0, prg_list.size() - 1)];
        a = {1'b1, w};
        if (cfg_prg_banks < 2) a[14] = 1'($urandom_range(0, 1));
      end
      send_access(FUNC_CPU_READ, a, d);
    end else if (pick < 38) begin
      send_access(FUNC_CPU_WRITE, a, d);
    end else if (pick < 54) begin
      send_access(FUNC_PPU_WRITE, {3'b000, a[12:0]}, d);
    end else if (pick < 70) begin
      if (chr_list.size() != 0 && $urandom_range(0, 4) != 0) begin
        w = chr_list[$urandom_range(0, chr_list.size() - 1)];
        if (w[14:13] != chr_bank_sel) begin
          bank_hi = 6'($urandom_range(0, 63));
          send_access(FUNC_CPU_WRITE, 16'($urandom_range(0, 16'hFFFF)), {bank_hi, w[14:13]});
        end
        a = {3'b000, w[12:0]};
      end else begin
        a[15:13] = 3'b000;
      end
      send_access(FUNC_PPU_READ, a, d);
    end else if (pick < 80) begin
      if (a < 16'h2000) a[13] = 1'b1;
      send_access(FUNC_PPU_WRITE, a, d);
    end else if (pick < 92) begin
      if (nt_list.size() != 0 && $urandom_range(0, 4) != 0) begin
        n = nt_list[$urandom_range(0, nt_list.size() - 1)];
        a[9:0] = n[9:0];
        if (cfg_mirror == MIRROR_VERTICAL) a[10] = n[10];
        else a[11] = n[10];
      end
      if (a < 16'h2000) a[13] = 1'b1;
      send_access(FUNC_PPU_READ, a, d);
    end else if (pick < 96) begin
      f = 3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
      send_access(f, a, d);
    end else begin
      f = 3'($urandom_range(FUNC_CPU_READ, FUNC_LAST_UNUSED));
      send_access(f, a, d);
    end
  endtask

  task automatic test_prg_directed();
    send_access(FUNC_LOAD_PRG, 16'h0000, 8'hA5);
    send_access(FUNC_LOAD_PRG, 16'h7FFF, 8'hFF);
    send_access(FUNC_LOAD_PRG, 16'h3FFF, 8'h5A);
    send_access(FUNC_LOAD_PRG, 16'h8000, 8'h11);
    send_access(FUNC_LOAD_PRG, 16'hFFFF, 8'h00);
    send_access(FUNC_CPU_READ, 16'h8000, 8'h00);
    send_access(FUNC_CPU_READ, 16'hFFFF, 8'hFF);
    send_access(FUNC_CPU_READ, 16'h7FFF, 8'h00);
    send_access(FUNC_CPU_READ, 16'h0000, 8'h00);
    write_config(CFG_PRG_BANKS, 3'd1);
    send_access(FUNC_CPU_READ, 16'hC000, 8'h00);
    send_access(FUNC_CPU_READ, 16'hFFFF, 8'h00);
    write_config(CFG_PRG_BANKS, 3'b100);
    send_access(FUNC_CPU_READ, 16'hBFFF, 8'h00);
    write_config(CFG_PRG_BANKS, 3'd3);
  endtask

  task automatic test_chr_directed();
    send_access(FUNC_CPU_WRITE, 16'hFFFF, 8'hFF);
    send_access(FUNC_PPU_WRITE, 16'h1FFF, 8'h00);
    send_access(FUNC_PPU_READ, 16'h1FFF, 8'h00);
    send_access(FUNC_CPU_WRITE, 16'h0000, 8'h00);
    send_access(FUNC_PPU_WRITE, 16'h0000, 8'hFF);
    send_access(FUNC_PPU_READ, 16'h0000, 8'h00);
    write_config(CFG_CHR_BANKS, 3'd1);
    send_access(FUNC_CPU_WRITE, 16'h1234, 8'h01);
    send_access(FUNC_PPU_READ, 16'h0000, 8'h00);
    write_config(CFG_CHR_BANKS, 3'd0);
    send_access(FUNC_CPU_WRITE, 16'h8000, 8'h00);
    send_access(FUNC_PPU_WRITE, 16'h0000, 8'h42);
    write_config(CFG_CHR_BANKS, 3'd7);
    send_access(FUNC_PPU_READ, 16'h0000, 8'h00);
  endtask

  task automatic test_nametable_and_unused();
    send_access(FUNC_PPU_WRITE, 16'h2000, 8'h3C);
    send_access(FUNC_PPU_WRITE, 16'hFFFF, 8'hC3);
    send_access(FUNC_PPU_READ, 16'h3000, 8'h00);
    send_access(FUNC_PPU_READ, 16'h2FFF, 8'h00);
    write_config(CFG_MIRROR_MODE, {2'b11, MIRROR_VERTICAL});
    send_access(FUNC_PPU_WRITE, 16'h2400, 8'h77);
    send_access(FUNC_PPU_READ, 16'h2C00, 8'h00);
    send_access(FUNC_FIRST_UNUSED, 16'hFFFF, 8'hFF);
    send_access(FUNC_LAST_UNUSED, 16'h0000, 8'h5A);
    write_config(CFG_NO_REGISTER, 3'd7);
  endtask

  task automatic test_receiver_hold_off();
    hold_count <= hold_count + 1;
    burst_left = 64;
    repeat (40) random_access();
    drain_results();
  endtask

  task automatic test_sender_pause();
    repeat (20) random_access();
    drain_results();
    repeat (20) random_access();
    drain_results();
  endtask

  task automatic test_random_settings();
    int phase_prg [8] = '{2, 1, 0, 3, 2, 1, 3, 2};
    int phase_chr [8] = '{4, 1, 0, 7, 2, 4, 3, 5};
    int phase_mirror [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) begin
        write_config(CFG_PRG_BANKS, 3'($urandom_range(0, 7)));
        write_config(CFG_CHR_BANKS, 3'($urandom_range(0, 7)));
        write_config(CFG_MIRROR_MODE, 3'($urandom_range(0, 7)));
      end else begin
        write_config(CFG_PRG_BANKS, 3'(phase_prg[phase]));
        write_config(CFG_CHR_BANKS, 3'(phase_chr[phase]));
        write_config(CFG_MIRROR_MODE, 3'(phase_mirror[phase]));
      end
      repeat (170) random_access();
      if (phase == 3) test_receiver_hold_off();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_prg_directed();
    test_chr_directed();
    test_nametable_and_unused();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_settings();
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
